// ===== rtl/cnlc_pkg.sv =====
// Shared types and constants for the card number Luhn checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cnlc_pkg;

  // ASCII codes that bound the decimal digits
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // Count saturation point
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;
  localparam logic [LEN_W-1:0]     MIN_LENGTH_RST = 5'd13;
  localparam logic [LEN_W-1:0]     MAX_LENGTH_RST = 5'd16;

  // Accepted prefix digits
  localparam logic [DIGIT_W-1:0] PFX_VISA     = 4'd4;
  localparam logic [DIGIT_W-1:0] PFX_MASTER   = 4'd5;
  localparam logic [DIGIT_W-1:0] PFX_DISCOVER = 4'd6;
  localparam logic [DIGIT_W-1:0] PFX_AMEX_HI  = 4'd3;
  localparam logic [DIGIT_W-1:0] PFX_AMEX_LO  = 4'd7;

  // Verdict status codes
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_LENGTH    = 3'd1,
    ST_BAD_PREFIX    = 3'd2,
    ST_CHECKSUM_FAIL = 3'd3,
    ST_NON_DIGIT     = 3'd4
  } status_e;

  // One character of the number
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } item_t;

  // Verdict for a finished number
  typedef struct packed {
    logic                valid_res;
    status_e             status;
    logic [DIGIT_W-1:0]  checksum_mod;
  } verdict_t;

  // Luhn doubling of one digit, folded back to a single digit
  function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] t;
    t = {d, 1'b0};
    luhn_double = (t > 5'd9) ? DIGIT_W'(t - 5'd9) : t[DIGIT_W-1:0];
  endfunction

  // Sum of two values below ten, modulo ten
  function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_mod10 = (s >= 5'd10) ? DIGIT_W'(s - 5'd10) : s[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cnlc_stream_if.sv =====
// Valid/ready channel interfaces for the card number Luhn checker.
// Input channel carries one character, output channel one verdict; uses cnlc_pkg.
`default_nettype none

interface cnlc_in_if
  import cnlc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

interface cnlc_out_if
  import cnlc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [2:0]         status;
  logic [DIGIT_W-1:0] checksum_mod;

  modport source (output valid, output valid_res, output status, output checksum_mod,
                  input ready);
  modport sink   (input valid, input valid_res, input status, input checksum_mod,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/cnlc_accum.sv =====
// Per-number accumulator: digit count, both Luhn parity sums, prefix digits.
// Produces the verdict from the updated state; uses cnlc_pkg.
`default_nettype none

module cnlc_accum
  import cnlc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire item_t             item_i,
  input  wire logic [LEN_W-1:0]  min_len_i,
  input  wire logic [LEN_W-1:0]  max_len_i,
  output verdict_t               verdict_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [DIGIT_W-1:0] sum_even_q, sum_even_d;
  logic [DIGIT_W-1:0] sum_odd_q, sum_odd_d;
  logic [DIGIT_W-1:0] first_q, first_d;
  logic [DIGIT_W-1:0] second_q, second_d;
  logic               bad_q, bad_d;

  logic               is_digit;
  logic [DIGIT_W-1:0] digit;
  logic [CHAR_W-1:0]  char_off;
  logic               prefix_ok;

  // Decode the character
  assign is_digit = (item_i.digit_char >= ASCII_ZERO) && (item_i.digit_char <= ASCII_NINE);
  assign char_off = item_i.digit_char - ASCII_ZERO;
  assign digit    = char_off[DIGIT_W-1:0];

  // Fold this character into the running state
  always_comb begin
    count_d    = count_q;
    sum_even_d = sum_even_q;
    sum_odd_d  = sum_odd_q;
    first_d    = first_q;
    second_d   = second_q;
    bad_d      = bad_q;
    if (is_digit) begin
      // an even tail after this digit means it is undoubled, and vice versa
      sum_even_d = add_mod10(sum_odd_q, digit);
      sum_odd_d  = add_mod10(sum_even_q, luhn_double(digit));
      if (count_q == '0) begin
        first_d = digit;
      end
      if (count_q == COUNT_W'(1)) begin
        second_d = digit;
      end
      if (count_q != COUNT_MAX) begin
        count_d = count_q + COUNT_W'(1);
      end
    end else begin
      bad_d = 1'b1;
    end
  end

  // Judge the number as it stands after this character
  always_comb begin
    prefix_ok = 1'b0;
    if (count_d != '0) begin
      if (first_d inside {PFX_VISA, PFX_MASTER, PFX_DISCOVER}) begin
        prefix_ok = 1'b1;
      end else if (first_d == PFX_AMEX_HI && count_d >= COUNT_W'(2) &&
                   second_d == PFX_AMEX_LO) begin
        prefix_ok = 1'b1;
      end
    end

    if (bad_d) begin
      verdict_o.status = ST_NON_DIGIT;
    end else if (count_d < min_len_i || count_d > max_len_i) begin
      verdict_o.status = ST_BAD_LENGTH;
    end else if (!prefix_ok) begin
      verdict_o.status = ST_BAD_PREFIX;
    end else if (sum_even_d != '0) begin
      verdict_o.status = ST_CHECKSUM_FAIL;
    end else begin
      verdict_o.status = ST_OK;
    end
    verdict_o.valid_res    = (verdict_o.status == ST_OK);
    verdict_o.checksum_mod = sum_even_d;
  end

  // Advance on each transaction; clear after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      sum_even_q <= '0;
      sum_odd_q  <= '0;
      first_q    <= '0;
      second_q   <= '0;
      bad_q      <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last) begin
        count_q    <= '0;
        sum_even_q <= '0;
        sum_odd_q  <= '0;
        first_q    <= '0;
        second_q   <= '0;
        bad_q      <= 1'b0;
      end else begin
        count_q    <= count_d;
        sum_even_q <= sum_even_d;
        sum_odd_q  <= sum_odd_d;
        first_q    <= first_d;
        second_q   <= second_d;
        bad_q      <= bad_d;
      end
    end
  end

  // The last character always leaves a clean slate
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last |=> count_q == '0 && !bad_q && sum_even_q == '0)
    else $error("state not cleared after last character");

  // A digit in the middle of a number bumps the count until saturation
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last && is_digit && count_q != COUNT_MAX
    |=> count_q == $past(count_q) + COUNT_W'(1))
    else $error("digit count did not advance");

  // A non-digit in the middle of a number is remembered
  a_bad_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last && !is_digit |=> bad_q)
    else $error("non-digit not recorded");

endmodule

`default_nettype wire

// ===== rtl/cnlc_regs.sv =====
// Configuration registers of the card number Luhn checker: length bounds.
// Plain write port, no read-back; uses cnlc_pkg.
`default_nettype none

module cnlc_regs
  import cnlc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 we_i,
  input  wire logic [CFG_IDX_W-1:0] idx_i,
  input  wire logic [LEN_W-1:0]     wdata_i,
  output logic      [LEN_W-1:0]     min_len_o,
  output logic      [LEN_W-1:0]     max_len_o
);

  logic [LEN_W-1:0] min_len_q, max_len_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LENGTH_RST;
      max_len_q <= MAX_LENGTH_RST;
    end else if (we_i) begin
      case (idx_i)
        REG_MIN_LENGTH: min_len_q <= wdata_i;
        REG_MAX_LENGTH: max_len_q <= wdata_i;
        default: ;
      endcase
    end
  end

  assign min_len_o = min_len_q;
  assign max_len_o = max_len_q;

endmodule

`default_nettype wire

// ===== rtl/card_number_luhn_checker.sv =====
// Top level of the card number Luhn checker: input register, accumulator, result register.
// Depends on cnlc_pkg, cnlc_stream_if, cnlc_regs and cnlc_accum.
//
// Feed a card number one ASCII character per transaction, most significant digit first,
// with last set on the final character. The block takes one character every clock unless
// a last character waits on a busy result register; the only loop is the update of the
// digit count and the two mod-10 Luhn sums between the input register and the accumulator
// state, so throughput is one character per cycle under that condition. The result
// register parts the two sides: while a verdict waits, further characters of the next
// number keep flowing, and only a second last character stalls. Each number gives exactly
// one verdict: valid_res, a status code (non-digit seen, bad length, bad prefix, checksum
// fail, checked in that order, else ok) and the Luhn sum modulo ten. Lengths saturate at
// 31 digits. The length bounds sit at index 0 (min, reset 13) and 1 (max, reset 16); the
// user must write them only while no number is in flight; the block does not enforce it.
`default_nettype none

module card_number_luhn_checker
  import cnlc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LEN_W-1:0]     cfg_wdata_i,
  cnlc_in_if.sink                   in_i,
  cnlc_out_if.source                out_o
);

  logic             s1_valid_q;
  item_t            s1_item_q;
  logic             s1_adv;
  logic             out_valid_q;
  verdict_t         out_q;
  verdict_t         verdict;
  logic             out_free;
  logic [LEN_W-1:0] min_len, max_len;

  cnlc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (cfg_we_i),
    .idx_i     (cfg_idx_i),
    .wdata_i   (cfg_wdata_i),
    .min_len_o (min_len),
    .max_len_o (max_len)
  );

  // A staged character moves on unless it is last and the result slot is busy
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!s1_item_q.last || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q.digit_char <= in_i.digit_char;
      s1_item_q.last       <= in_i.last;
    end
  end

  cnlc_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_adv),
    .item_i    (s1_item_q),
    .min_len_i (min_len),
    .max_len_i (max_len),
    .verdict_o (verdict)
  );

  // Result register: load on a last character, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_item_q.last) begin
      out_q <= verdict;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.valid_res    = out_q.valid_res;
  assign out_o.status       = out_q.status;
  assign out_o.checksum_mod = out_q.checksum_mod;

  // A fresh verdict comes only from a last character that moved on
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_item_q.last))
    else $error("verdict without a last character");

  // A waiting verdict blocks only a last character
  a_nonlast_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_item_q.last |-> in_i.ready)
    else $error("non-last character stalled");

  // A verdict leaves only when taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_o.ready))
    else $error("verdict dropped without a transaction");

  // A verdict carries a status that agrees with its pass flag
  a_pass_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.valid_res == (out_q.status == ST_OK))
    else $error("pass flag disagrees with status");

endmodule

`default_nettype wire
